[rtl/core/wssh_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wssh_pkg
// Shared constants for the windowed substitution score block: field widths,
// score table geometry, opcodes and the threshold reset value.
// ----------------------------------------------------------------------------
package wssh_pkg;

   localparam int WINDOW_DEFAULT = 20;
   localparam int CODE_COUNT     = 32;

   localparam int CODE_W  = 5;
   localparam int ENTRY_W = 8;
   localparam int POS_W   = 16;
   localparam int PROT_W  = 16;
   localparam int SUM_W   = 14;
   localparam int THR_W   = 12;

   localparam int SCORE_DEPTH = CODE_COUNT * CODE_COUNT;
   localparam int SCORE_AW    = $clog2(SCORE_DEPTH);

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_PAIR = 1'b1;

   localparam logic signed [THR_W-1:0] THRESHOLD_RESET = 12'sd35;

endpackage
`default_nettype wire

[rtl/core/windowed_substitution_score_hits.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_substitution_score_hits
// Looks up substitution scores of residue pairs in a loaded score table and
// keeps a sliding window sum; reports window score and hit once full.
// ----------------------------------------------------------------------------
// a pair is registered into the score stage, which updates the running sum;
//   its result is registered at the output; loads write the table directly
// throughput: one item per cycle unless stalled
// reset: clears window fill, position, sum and output valid; threshold is 35;
//   the score table holds garbage until loaded
module windowed_substitution_score_hits #(
   parameter int WINDOW = wssh_pkg::WINDOW_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic                                  req_opcode,
   input  wire logic [wssh_pkg::CODE_W-1:0]           req_residue_a,
   input  wire logic [wssh_pkg::CODE_W-1:0]           req_residue_b,
   input  wire logic signed [wssh_pkg::ENTRY_W-1:0]   req_entry_value,
   input  wire logic                                  req_first_pair,
   input  wire logic [wssh_pkg::POS_W-1:0]            req_start_offset,
   input  wire logic [wssh_pkg::PROT_W-1:0]           req_protein_index,
   input  wire logic                                  req_last_pair,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [wssh_pkg::POS_W-1:0]                 rsp_window_position,
   output logic [wssh_pkg::PROT_W-1:0]                rsp_protein_id,
   output logic signed [wssh_pkg::SUM_W-1:0]          rsp_window_score,
   output logic                                       rsp_hit,
   output logic                                       rsp_last_window,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic signed [wssh_pkg::THR_W-1:0]     csr_hit_threshold
);

   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int FILL_W = $clog2(WINDOW + 1);

   typedef struct packed {
      logic                               produces;
      logic [SLOT_W-1:0]                  slot;
      logic                               bypass;
      logic                               old_zero;
      logic                               score_zero;
      logic                               first;
      logic                               last;
      logic [wssh_pkg::POS_W-1:0]         position;
      logic [wssh_pkg::PROT_W-1:0]        protein;
   } stage_type;

   // memories
   logic signed [wssh_pkg::ENTRY_W-1:0] score_mem [wssh_pkg::SCORE_DEPTH];
   logic signed [wssh_pkg::ENTRY_W-1:0] ring_mem [WINDOW];
   logic signed [wssh_pkg::ENTRY_W-1:0] score_rd_ff;
   logic signed [wssh_pkg::ENTRY_W-1:0] ring_rd_ff;

   // accept-side control state
   logic [SLOT_W-1:0]             slot_ff, slot_in;
   logic [FILL_W-1:0]             fill_ff, fill_in;
   logic [wssh_pkg::POS_W-1:0]    widx_ff, widx_in;
   logic [wssh_pkg::POS_W-1:0]    base_ff, base_in;
   logic [wssh_pkg::PROT_W-1:0]   prot_ff, prot_in;

   // score stage
   logic                          s1_valid_ff, s1_valid_in;
   stage_type                     s1_ff, s1_in;
   logic signed [wssh_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic signed [wssh_pkg::ENTRY_W-1:0] last_score_ff;

   logic signed [wssh_pkg::THR_W-1:0]   threshold_ff;
   logic                                rsp_valid_ff;

   logic                          accept, accept_pair, accept_load;
   logic                          codes_ok;
   logic [wssh_pkg::SCORE_AW-1:0] score_addr;
   logic [SLOT_W-1:0]             slot_cur;
   logic [FILL_W-1:0]             fill_cur;
   logic [wssh_pkg::POS_W-1:0]    widx_cur;
   logic                          produces_cur;
   logic                          out_free, s1_adv;
   logic signed [wssh_pkg::ENTRY_W-1:0] s1_score, s1_old;
   logic signed [wssh_pkg::SUM_W-1:0]   sum_base, sum_new;

   assign csr_ready   = 1'b1;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign s1_adv      = s1_valid_ff && (!s1_ff.produces || out_free);
   assign req_stall   = s1_valid_ff && !s1_adv;
   assign accept      = req_valid && !req_stall;
   assign accept_pair = accept && (req_opcode == wssh_pkg::OP_PAIR);
   assign accept_load = accept && (req_opcode == wssh_pkg::OP_LOAD);

   assign codes_ok   = (32'(req_residue_a) < wssh_pkg::CODE_COUNT) &&
                       (32'(req_residue_b) < wssh_pkg::CODE_COUNT);
   assign score_addr = wssh_pkg::SCORE_AW'(32'(req_residue_a) * wssh_pkg::CODE_COUNT
                                           + 32'(req_residue_b));

   // pair bookkeeping at acceptance
   always_comb begin
      slot_cur     = req_first_pair ? '0 : slot_ff;
      fill_cur     = req_first_pair ? '0 : fill_ff;
      widx_cur     = req_first_pair ? '0 : widx_ff;
      base_in      = req_first_pair ? req_start_offset : base_ff;
      prot_in      = req_first_pair ? req_protein_index : prot_ff;
      produces_cur = (fill_cur >= FILL_W'(WINDOW - 1));
      fill_in      = (fill_cur == FILL_W'(WINDOW)) ? fill_cur : fill_cur + 1'b1;
      slot_in      = (slot_cur == SLOT_W'(WINDOW - 1)) ? '0 : slot_cur + 1'b1;
      widx_in      = produces_cur ? widx_cur + 1'b1 : widx_cur;

      s1_in.produces   = produces_cur;
      s1_in.slot       = slot_cur;
      // same ring slot written by the pair leaving the score stage right now
      s1_in.bypass     = s1_adv && (s1_ff.slot == slot_cur);
      s1_in.old_zero   = (fill_cur != FILL_W'(WINDOW));
      s1_in.score_zero = !codes_ok;
      s1_in.first      = req_first_pair;
      s1_in.last       = req_last_pair;
      s1_in.position   = base_in + widx_cur;
      s1_in.protein    = prot_in;
   end

   always_comb begin
      s1_valid_in = accept_pair ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      s1_score    = s1_ff.score_zero ? '0 : score_rd_ff;
      if (s1_ff.old_zero) begin
         s1_old = '0;
      end else if (s1_ff.bypass) begin
         s1_old = last_score_ff;
      end else begin
         s1_old = ring_rd_ff;
      end
      sum_base = s1_ff.first ? '0 : sum_ff;
      sum_new  = sum_base + wssh_pkg::SUM_W'(s1_score) - wssh_pkg::SUM_W'(s1_old);
      sum_in   = s1_adv ? sum_new : sum_ff;
   end

   always_ff @(posedge clock) begin
      if (accept_load && codes_ok) begin
         score_mem[score_addr] <= req_entry_value;
      end
      if (accept_pair) begin
         score_rd_ff <= score_mem[score_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         ring_mem[s1_ff.slot] <= s1_score;
      end
      if (accept_pair) begin
         ring_rd_ff <= ring_mem[slot_cur];
      end
   end

   always_ff @(posedge clock) begin
      if (accept_pair) begin
         s1_ff <= s1_in;
      end
      if (s1_adv) begin
         last_score_ff <= s1_score;
      end
      if (s1_adv && s1_ff.produces) begin
         rsp_window_position <= s1_ff.position;
         rsp_protein_id      <= s1_ff.protein;
         rsp_window_score    <= sum_new;
         rsp_hit             <= (sum_new >= wssh_pkg::SUM_W'(threshold_ff));
         rsp_last_window     <= s1_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         fill_ff      <= '0;
         widx_ff      <= '0;
         base_ff      <= '0;
         prot_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         threshold_ff <= wssh_pkg::THRESHOLD_RESET;
      end else begin
         if (accept_pair) begin
            slot_ff <= slot_in;
            fill_ff <= fill_in;
            widx_ff <= widx_in;
            base_ff <= base_in;
            prot_ff <= prot_in;
         end
         s1_valid_ff <= s1_valid_in;
         sum_ff      <= sum_in;
         if (s1_adv && s1_ff.produces) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            threshold_ff <= csr_hit_threshold;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

[rtl/core/wssh_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wssh_checker
// Port-level checks for the windowed substitution score block, bound to the
// top level.
// ----------------------------------------------------------------------------
module wssh_checker (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic                                  req_stall,
   input wire logic                                  rsp_valid,
   input wire logic                                  rsp_stall,
   input wire logic [wssh_pkg::POS_W-1:0]            rsp_window_position,
   input wire logic [wssh_pkg::PROT_W-1:0]           rsp_protein_id,
   input wire logic signed [wssh_pkg::SUM_W-1:0]     rsp_window_score,
   input wire logic                                  rsp_hit,
   input wire logic                                  rsp_last_window,
   input wire logic                                  csr_valid,
   input wire logic                                  csr_ready,
   input wire logic signed [wssh_pkg::THR_W-1:0]     csr_hit_threshold
);

   logic signed [wssh_pkg::THR_W-1:0] thr_ff;

   // shadow of the threshold register as written through the port
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= wssh_pkg::THRESHOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         thr_ff <= csr_hit_threshold;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_window_position) &&
      $stable(rsp_protein_id) && $stable(rsp_window_score) &&
      $stable(rsp_hit) && $stable(rsp_last_window))
      else $error("stalled result changed");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a stalled result");

   a_hit_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hit == (rsp_window_score >= wssh_pkg::SUM_W'(thr_ff)))
      else $error("hit flag disagrees with score and threshold");

endmodule

bind windowed_substitution_score_hits wssh_checker u_wssh_checker (
   .clock               (clock),
   .reset               (reset),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_window_position (rsp_window_position),
   .rsp_protein_id      (rsp_protein_id),
   .rsp_window_score    (rsp_window_score),
   .rsp_hit             (rsp_hit),
   .rsp_last_window     (rsp_last_window),
   .csr_valid           (csr_valid),
   .csr_ready           (csr_ready),
   .csr_hit_threshold   (csr_hit_threshold)
);
`default_nettype wire

[verif/tb_windowed_substitution_score_hits.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_windowed_substitution_score_hits
// Self-checking bench for the windowed substitution score block. A short
// table of directed items, then random comparisons with interleaved score
// table loads, run under several hit thresholds and idle/stall mixes.
// Every result is checked field by field against directed values or a predictor.
// ----------------------------------------------------------------------------
module tb_windowed_substitution_score_hits;

   localparam int WIN             = wssh_pkg::WINDOW_DEFAULT;
   localparam int RING_W          = (WIN > 1) ? $clog2(WIN) : 1;
   localparam int PHASES          = 6;
   localparam int PHASE_W         = $clog2(PHASES);
   localparam int ITEMS_PER_PHASE = 105;
   localparam int STALL_LIMIT     = 2000;
   localparam int SETTLE_CYCLES   = 4;
   localparam logic signed [wssh_pkg::THR_W-1:0] THR_MIN =
      {1'b1, {(wssh_pkg::THR_W-1){1'b0}}};
   localparam logic signed [wssh_pkg::THR_W-1:0] THR_MAX =
      {1'b0, {(wssh_pkg::THR_W-1){1'b1}}};

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic                                opcode;
      logic [wssh_pkg::CODE_W-1:0]         residue_a;
      logic [wssh_pkg::CODE_W-1:0]         residue_b;
      logic signed [wssh_pkg::ENTRY_W-1:0] entry_value;
      logic                                first_pair;
      logic [wssh_pkg::POS_W-1:0]          start_offset;
      logic [wssh_pkg::PROT_W-1:0]         protein_index;
      logic                                last_pair;
   } pair_item_type;

   typedef struct packed {
      logic [wssh_pkg::POS_W-1:0]        window_position;
      logic [wssh_pkg::PROT_W-1:0]       protein_id;
      logic signed [wssh_pkg::SUM_W-1:0] window_score;
      logic                              hit;
      logic                              last_window;
   } window_result_type;

   typedef struct packed {
      pair_item_type     item;
      logic              known;
      logic              has_result;
      window_result_type result;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                req_valid         = 1'b0;
   logic                                req_stall;
   logic                                req_opcode        = wssh_pkg::OP_LOAD;
   logic [wssh_pkg::CODE_W-1:0]         req_residue_a     = '0;
   logic [wssh_pkg::CODE_W-1:0]         req_residue_b     = '0;
   logic signed [wssh_pkg::ENTRY_W-1:0] req_entry_value   = '0;
   logic                                req_first_pair    = 1'b0;
   logic [wssh_pkg::POS_W-1:0]          req_start_offset  = '0;
   logic [wssh_pkg::PROT_W-1:0]         req_protein_index = '0;
   logic                                req_last_pair     = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_stall         = 1'b0;
   logic [wssh_pkg::POS_W-1:0]          rsp_window_position;
   logic [wssh_pkg::PROT_W-1:0]         rsp_protein_id;
   logic signed [wssh_pkg::SUM_W-1:0]   rsp_window_score;
   logic                                rsp_hit;
   logic                                rsp_last_window;
   logic                                csr_valid         = 1'b0;
   logic                                csr_ready;
   logic signed [wssh_pkg::THR_W-1:0]   csr_hit_threshold = wssh_pkg::THRESHOLD_RESET;

   // predictor state
   logic signed [wssh_pkg::ENTRY_W-1:0] score_table [wssh_pkg::SCORE_DEPTH];
   logic signed [wssh_pkg::ENTRY_W-1:0] win_ring [WIN] = '{default: '0};
   logic signed [wssh_pkg::SUM_W-1:0]   run_sum    = '0;
   int                                  fill_count = 0;
   logic [RING_W-1:0]                   ring_pos   = '0;
   logic [wssh_pkg::POS_W-1:0]          win_idx    = '0;
   logic [wssh_pkg::POS_W-1:0]          base_ofs   = '0;
   logic [wssh_pkg::PROT_W-1:0]         cur_prot   = '0;
   logic signed [wssh_pkg::THR_W-1:0]   hit_thr    = wssh_pkg::THRESHOLD_RESET;

   window_result_type             expected_windows [$];
   bit                            table_written [wssh_pkg::SCORE_DEPTH];
   logic [wssh_pkg::SCORE_AW-1:0] written_addr [$];
   stim_row_type                  directed_rows [$];
   idle_mode_type                 idle_mode   = IDLE_NONE;
   int                            errors      = 0;
   int                            idle_cycles = 0;

   windowed_substitution_score_hits #(.WINDOW(WIN)) uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_residue_a      (req_residue_a),
      .req_residue_b      (req_residue_b),
      .req_entry_value    (req_entry_value),
      .req_first_pair     (req_first_pair),
      .req_start_offset   (req_start_offset),
      .req_protein_index  (req_protein_index),
      .req_last_pair      (req_last_pair),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_window_position(rsp_window_position),
      .rsp_protein_id     (rsp_protein_id),
      .rsp_window_score   (rsp_window_score),
      .rsp_hit            (rsp_hit),
      .rsp_last_window    (rsp_last_window),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_hit_threshold  (csr_hit_threshold)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [wssh_pkg::SCORE_AW-1:0] table_addr(input pair_item_type it);
      return wssh_pkg::SCORE_AW'(int'(it.residue_a) * wssh_pkg::CODE_COUNT +
                                 int'(it.residue_b));
   endfunction

   // returns 1 when the item completes a window
   function automatic bit predict_window(input pair_item_type it,
                                         output window_result_type res);
      logic signed [wssh_pkg::ENTRY_W-1:0] entry;
      logic signed [wssh_pkg::ENTRY_W-1:0] leaving;
      bit                                  in_range;
      res      = '0;
      in_range = (int'(it.residue_a) < wssh_pkg::CODE_COUNT) &&
                 (int'(it.residue_b) < wssh_pkg::CODE_COUNT);
      if (it.opcode == wssh_pkg::OP_LOAD) begin
         if (in_range) score_table[table_addr(it)] = it.entry_value;
         return 1'b0;
      end
      if (it.first_pair) begin
         win_ring   = '{default: '0};
         run_sum    = '0;
         fill_count = 0;
         ring_pos   = '0;
         win_idx    = '0;
         base_ofs   = it.start_offset;
         cur_prot   = it.protein_index;
      end
      // codes outside the table score zero
      entry   = in_range ? score_table[table_addr(it)] : '0;
      leaving = win_ring[ring_pos];
      run_sum = run_sum + wssh_pkg::SUM_W'(entry) - wssh_pkg::SUM_W'(leaving);
      win_ring[ring_pos] = entry;
      ring_pos = (ring_pos == RING_W'(WIN - 1)) ? '0 : ring_pos + 1'b1;
      if (fill_count < WIN) fill_count++;
      if (fill_count < WIN) return 1'b0;
      res.window_position = base_ofs + win_idx;
      res.protein_id      = cur_prot;
      res.window_score    = run_sum;
      res.hit             = (run_sum >= wssh_pkg::SUM_W'(hit_thr));
      res.last_window     = it.last_pair;
      win_idx = win_idx + 1'b1;
      return 1'b1;
   endfunction

   function automatic pair_item_type mk_item(input logic op,
                                             input logic [wssh_pkg::CODE_W-1:0] ra,
                                             input logic [wssh_pkg::CODE_W-1:0] rb,
                                             input logic signed [wssh_pkg::ENTRY_W-1:0] val,
                                             input logic first,
                                             input logic [wssh_pkg::POS_W-1:0] ofs,
                                             input logic [wssh_pkg::PROT_W-1:0] prot,
                                             input logic last);
      pair_item_type it;
      it.opcode        = op;
      it.residue_a     = ra;
      it.residue_b     = rb;
      it.entry_value   = val;
      it.first_pair    = first;
      it.start_offset  = ofs;
      it.protein_index = prot;
      it.last_pair     = last;
      return it;
   endfunction

   task automatic add_row(input pair_item_type it, input logic known, input logic has_result,
                          input window_result_type res);
      stim_row_type row;
      row.item       = it;
      row.known      = known;
      row.has_result = has_result;
      row.result     = res;
      directed_rows.push_back(row);
   endtask

   task automatic send_item(input pair_item_type it);
      int idle_pct;
      idle_pct = (idle_mode == IDLE_SENDER) ? 67 : (idle_mode == IDLE_BOTH) ? 11 : 0;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_opcode        <= it.opcode;
      req_residue_a     <= it.residue_a;
      req_residue_b     <= it.residue_b;
      req_entry_value   <= it.entry_value;
      req_first_pair    <= it.first_pair;
      req_start_offset  <= it.start_offset;
      req_protein_index <= it.protein_index;
      req_last_pair     <= it.last_pair;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic transfer_item(input pair_item_type it, output bit has,
                                output window_result_type res);
      logic [wssh_pkg::SCORE_AW-1:0] addr;
      send_item(it);
      has  = predict_window(it, res);
      addr = table_addr(it);
      if (it.opcode == wssh_pkg::OP_LOAD && !table_written[addr]) begin
         table_written[addr] = 1'b1;
         written_addr.push_back(addr);
      end
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_windows.size() != 0) @(posedge clock);
   endtask

   task automatic write_threshold(input logic signed [wssh_pkg::THR_W-1:0] thr);
      pause_until_drained();
      // a trailing pair that only fills the window may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid         <= 1'b1;
      csr_hit_threshold <= thr;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      hit_thr = thr;
   endtask

   task automatic run_random(input int n_items);
      pair_item_type                 it;
      window_result_type             res;
      bit                            has;
      int                            pairs_left;
      logic [wssh_pkg::SCORE_AW-1:0] addr;
      int                            pick;
      pairs_left = 0;
      for (int k = 0; k < n_items; k++) begin
         if (k == n_items / 2) pause_until_drained();
         it               = '0;
         it.start_offset  = wssh_pkg::POS_W'($urandom);
         it.protein_index = wssh_pkg::PROT_W'($urandom);
         if (written_addr.size() < 8 || $urandom_range(99) < 20) begin
            // load; comparison controls ride along and must be ignored
            it.opcode     = wssh_pkg::OP_LOAD;
            it.residue_a  = wssh_pkg::CODE_W'($urandom);
            it.residue_b  = wssh_pkg::CODE_W'($urandom);
            pick          = $urandom_range(7);
            it.entry_value = (pick == 0) ? 8'sh7f : (pick == 1) ? 8'sh80 : 8'($urandom);
            it.first_pair = 1'($urandom);
            it.last_pair  = 1'($urandom);
         end else begin
            it.opcode = wssh_pkg::OP_PAIR;
            if (pairs_left == 0) begin
               pairs_left = ($urandom_range(7) == 0) ? $urandom_range(1, WIN - 1)
                                                     : $urandom_range(WIN, WIN + 25);
               // now and then a new comparison continues the old state
               it.first_pair = ($urandom_range(15) != 0);
               if ($urandom_range(3) == 0) it.start_offset = 16'hfff0 | 16'($urandom_range(15));
            end
            addr         = written_addr[$urandom_range(written_addr.size() - 1)];
            it.residue_a = wssh_pkg::CODE_W'(addr / wssh_pkg::CODE_COUNT);
            it.residue_b = wssh_pkg::CODE_W'(addr % wssh_pkg::CODE_COUNT);
            it.entry_value = wssh_pkg::ENTRY_W'($urandom);
            pairs_left--;
            it.last_pair = (pairs_left == 0) || ($urandom_range(31) == 0);
         end
         transfer_item(it, has, res);
         if (has) expected_windows.push_back(res);
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected 0x%h, actual 0x%h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : result_check
      window_result_type want;
      int                stall_pct;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_windows.size() == 0) begin
            $display("%0t ns: unexpected result transfer, expected none, actual pos 0x%h score %0d",
                     $time, rsp_window_position, rsp_window_score);
            errors++;
         end else begin
            want = expected_windows.pop_front();
            check_field("window_position", want.window_position, rsp_window_position);
            check_field("protein_id", want.protein_id, rsp_protein_id);
            check_field("window_score", 16'(want.window_score), 16'(rsp_window_score));
            check_field("hit", 16'(want.hit), 16'(rsp_hit));
            check_field("last_window", 16'(want.last_window), 16'(rsp_last_window));
         end
      end
      stall_pct = (idle_mode == IDLE_RECEIVER) ? 67 : (idle_mode == IDLE_BOTH) ? 11 : 0;
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic signed [wssh_pkg::THR_W-1:0] phase_thr [PHASES];
      idle_mode_type                     phase_mode [PHASES];
      window_result_type                 res;
      bit                                has;
      int                                spread;

      // table: max entry, min entry, then a window of one min score and max scores
      add_row(mk_item(wssh_pkg::OP_LOAD, 5'd0, 5'd0, 8'sh7f, 1'b0, 16'h0000, 16'h0000, 1'b0),
              1'b1, 1'b0, '0);
      add_row(mk_item(wssh_pkg::OP_LOAD, 5'd31, 5'd31, 8'sh80, 1'b0, 16'h0000, 16'h0000, 1'b0),
              1'b1, 1'b0, '0);
      // last pair flagged while the window is still filling: no result
      add_row(mk_item(wssh_pkg::OP_PAIR, 5'd31, 5'd31, 8'sh00, 1'b1, 16'hffff, 16'hffff, 1'b1),
              1'b1, 1'b0, '0);
      for (int i = 0; i < 9; i++)
         add_row(mk_item(wssh_pkg::OP_PAIR, 5'd0, 5'd0, 8'sh00, 1'b0, 16'h1234, 16'h5678, 1'b0),
                 1'b0, 1'b0, '0);
      // load mid-comparison with first and last set: window state untouched
      add_row(mk_item(wssh_pkg::OP_LOAD, 5'd21, 5'd10, 8'sh00, 1'b1, 16'haaaa, 16'h5555, 1'b1),
              1'b1, 1'b0, '0);
      for (int i = 0; i < 9; i++)
         add_row(mk_item(wssh_pkg::OP_PAIR, 5'd0, 5'd0, 8'sh00, 1'b0, 16'h1234, 16'h5678, 1'b0),
                 1'b0, 1'b0, '0);
      add_row(mk_item(wssh_pkg::OP_PAIR, 5'd0, 5'd0, 8'sh00, 1'b0, 16'h0000, 16'h0000, 1'b0),
              1'b1, 1'b1, '{16'hffff, 16'hffff, 14'sd2285, 1'b1, 1'b0});
      // position wraps past 0xffff
      add_row(mk_item(wssh_pkg::OP_PAIR, 5'd21, 5'd10, 8'sh00, 1'b0, 16'h0000, 16'h0000, 1'b1),
              1'b1, 1'b1, '{16'h0000, 16'hffff, 14'sd2413, 1'b1, 1'b1});
      // continues the same window after a last pair
      add_row(mk_item(wssh_pkg::OP_PAIR, 5'd21, 5'd10, 8'sh00, 1'b0, 16'h0000, 16'h0000, 1'b0),
              1'b0, 1'b0, '0);

      spread        = int'($urandom_range(800)) - 400;
      phase_thr[0]  = THR_MIN;
      phase_thr[1]  = THR_MAX;
      phase_thr[2]  = wssh_pkg::THR_W'(spread);
      phase_thr[3]  = '0;
      spread        = int'($urandom_range(400)) - 200;
      phase_thr[4]  = wssh_pkg::THR_W'(spread);
      phase_thr[5]  = wssh_pkg::THRESHOLD_RESET;
      phase_mode[0] = IDLE_NONE;
      phase_mode[1] = IDLE_SENDER;
      phase_mode[2] = IDLE_RECEIVER;
      phase_mode[3] = IDLE_BOTH;
      phase_mode[4] = IDLE_RECEIVER;
      phase_mode[5] = IDLE_SENDER;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         transfer_item(directed_rows[i].item, has, res);
         if (directed_rows[i].known) begin
            if (directed_rows[i].has_result) expected_windows.push_back(directed_rows[i].result);
         end else if (has) begin
            expected_windows.push_back(res);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         write_threshold(phase_thr[PHASE_W'(p)]);
         idle_mode = phase_mode[PHASE_W'(p)];
         run_random(ITEMS_PER_PHASE);
      end

      pause_until_drained();
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
